// File: rtl/core/vmt_pkg.sv
// Package: shared widths and constants for the vector move-towards block.
package vmt_pkg;

   // Default coordinate width (signed fixed point)
   localparam int COORD_BITS_DEF = 32;
   // Fraction bits of the coordinate format
   localparam int FRAC_BITS = 16;
   // Snap distance after reset: 0.01 in the coordinate format, rounded
   localparam int SNAP_RESET = ((1 << FRAC_BITS) + 50) / 100;
   // Number of axes
   localparam int LANES = 3;

endpackage

// File: rtl/core/vmt_chan_if.sv
// Interfaces: request, response and register write channels.
interface vmt_req_if #(parameter int CW = vmt_pkg::COORD_BITS_DEF) ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] cur_x;
   logic signed [CW-1:0] cur_y;
   logic signed [CW-1:0] cur_z;
   logic signed [CW-1:0] tgt_x;
   logic signed [CW-1:0] tgt_y;
   logic signed [CW-1:0] tgt_z;
   logic [CW-2:0]        max_step;
   modport source (output valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, max_step,
                   input ready);
   modport sink (input valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, max_step,
                 output ready);
endinterface

interface vmt_rsp_if #(parameter int CW = vmt_pkg::COORD_BITS_DEF) ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] new_x;
   logic signed [CW-1:0] new_y;
   logic signed [CW-1:0] new_z;
   logic                 reached;
   modport source (output valid, new_x, new_y, new_z, reached, input ready);
   modport sink (input valid, new_x, new_y, new_z, reached, output ready);
endinterface

interface vmt_csr_if #(parameter int CW = vmt_pkg::COORD_BITS_DEF) ();
   logic          valid;
   logic          ready;
   logic [CW-2:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/vmt_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
module vmt_sqrt_pipe #(
   parameter int ROOT_W = 34,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_v,
   input  logic [2*ROOT_W-1:0] in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_v,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int RW = ROOT_W + 2;

   logic [RW-1:0]       rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [2*ROOT_W-1:0] rad_ff  [ROOT_W];
   logic [SIDE_W-1:0]   side_ff [ROOT_W];
   logic [ROOT_W-1:0]   v_ff;

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [RW-1:0]       rem_p;
      logic [ROOT_W-1:0]   root_p;
      logic [2*ROOT_W-1:0] rad_p;
      logic [SIDE_W-1:0]   side_p;
      logic                v_p;
      logic [RW-1:0]       rem_t;
      logic [RW-1:0]       trial;
      logic                take;
      logic [RW-1:0]       rem_in;
      logic [ROOT_W-1:0]   root_in;

      if (s == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = in_rad;
         assign side_p = in_side;
         assign v_p    = in_v;
      end else begin : g_next
         assign rem_p  = rem_ff[s-1];
         assign root_p = root_ff[s-1];
         assign rad_p  = rad_ff[s-1];
         assign side_p = side_ff[s-1];
         assign v_p    = v_ff[s-1];
      end

      // Bring down two radicand bits and try the next root bit
      always_comb begin
         rem_t   = {rem_p[RW-3:0], rad_p[2*ROOT_W-1 -: 2]};
         trial   = {root_p, 2'b01};
         take    = (rem_t >= trial);
         rem_in  = take ? (rem_t - trial) : rem_t;
         root_in = {root_p[ROOT_W-2:0], take};
      end

      // Advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_p;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= {rad_p[2*ROOT_W-3:0], 2'b00};
            side_ff[s] <= side_p;
         end
      end
   end

   assign out_v    = v_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

// File: rtl/core/vmt_div_pipe.sv
// Pipelined restoring divider, three lanes sharing one divisor.
module vmt_div_pipe #(
   parameter int QW     = 31,
   parameter int DEN_W  = 34,
   parameter int NUM_W  = 64,
   parameter int SIDE_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_v,
   input  logic [NUM_W-1:0] in_num [vmt_pkg::LANES],
   input  logic [DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic             out_v,
   output logic [QW-1:0]    out_quo [vmt_pkg::LANES],
   output logic [SIDE_W-1:0] out_side
);
   import vmt_pkg::*;

   localparam int HI_W = NUM_W - QW;

   logic [DEN_W-1:0]  rem_ff  [QW][LANES];
   logic [QW-1:0]     low_ff  [QW][LANES];
   logic [DEN_W-1:0]  den_ff  [QW];
   logic [SIDE_W-1:0] side_ff [QW];
   logic [QW-1:0]     v_ff;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [DEN_W-1:0]  rem_p [LANES];
      logic [QW-1:0]     low_p [LANES];
      logic [DEN_W-1:0]  den_p;
      logic [SIDE_W-1:0] side_p;
      logic              v_p;
      logic [DEN_W-1:0]  rem_in [LANES];
      logic [QW-1:0]     low_in [LANES];

      if (s == 0) begin : g_first
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_p[l] = DEN_W'(in_num[l][NUM_W-1 -: HI_W]);
            assign low_p[l] = in_num[l][QW-1:0];
         end
         assign den_p  = in_den;
         assign side_p = in_side;
         assign v_p    = in_v;
      end else begin : g_next
         assign rem_p  = rem_ff[s-1];
         assign low_p  = low_ff[s-1];
         assign den_p  = den_ff[s-1];
         assign side_p = side_ff[s-1];
         assign v_p    = v_ff[s-1];
      end

      // Shift in one dividend bit per lane and subtract where it fits
      always_comb begin
         logic [DEN_W:0] t;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            t  = {rem_p[l], low_p[l][QW-1]};
            ge = (t >= {1'b0, den_p});
            rem_in[l] = ge ? DEN_W'(t - {1'b0, den_p}) : t[DEN_W-1:0];
            low_in[l] = {low_p[l][QW-2:0], ge};
         end
      end

      // Advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_p;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            low_ff[s]  <= low_in;
            den_ff[s]  <= den_p;
            side_ff[s] <= side_p;
         end
      end
   end

   assign out_v    = v_ff[QW-1];
   assign out_quo  = low_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

// File: rtl/core/vector_move_towards_core.sv
// Top level: moves a 3D point a bounded distance toward a target, fully pipelined.
//
// Channels: req_ch carries one word per move (current point, target point,
// largest step); rsp_ch returns one word per request (new point, reached flag),
// in request order. csr_ch writes the snap distance and is always ready; the
// user must write it only while no request is in flight; nothing enforces it.
// Throughput: one word per cycle while rsp_ch takes each word. Stages: A to D,
// the square-root pipeline (one root bit per stage, COORD_BITS+2 stages), E,
// the divider pipeline (one quotient bit per stage, COORD_BITS-1 stages) and
// the output stage.
// Stall: all stages advance together; when rsp_ch holds a word that is not
// taken, the whole pipeline freezes and req_ch.ready drops in the same cycle.
// No word is lost or repeated.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// snap distance to 0.01 in the coordinate format. Payload is not cleared.
// Reached words return the target itself; others return
// current + trunc(diff * step / length), saturated to COORD_BITS signed.
module vector_move_towards_core #(
   parameter int COORD_BITS = vmt_pkg::COORD_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   vmt_req_if.sink  req_ch,
   vmt_rsp_if.source rsp_ch,
   vmt_csr_if.sink  csr_ch
);
   import vmt_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int MW    = C + 1;          // magnitude of a difference
   localparam int RW    = MW + 1;         // root width
   localparam int SQW   = 2 * RW;         // sum of squares
   localparam int QW    = C - 1;          // quotient width
   localparam int NW    = MW + QW;        // product width
   localparam int SSIDE = 6 * C + LANES + LANES * MW + QW;
   localparam int DSIDE = 6 * C + LANES + 1;

   logic en;

   // Snap distance register
   logic [C-2:0] snap_ff;
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= (C-1)'(SNAP_RESET);
      end else if (csr_ch.valid) begin
         snap_ff <= csr_ch.data;
      end
   end

   // Stage A: capture the request word
   logic signed [C-1:0] a_cur_ff [LANES];
   logic signed [C-1:0] a_tgt_ff [LANES];
   logic [C-2:0]        a_step_ff;
   logic                a_v_ff;

   assign req_ch.ready = en;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_ch.valid;
      end
      if (en) begin
         a_cur_ff[0] <= req_ch.cur_x;
         a_cur_ff[1] <= req_ch.cur_y;
         a_cur_ff[2] <= req_ch.cur_z;
         a_tgt_ff[0] <= req_ch.tgt_x;
         a_tgt_ff[1] <= req_ch.tgt_y;
         a_tgt_ff[2] <= req_ch.tgt_z;
         a_step_ff   <= req_ch.max_step;
      end
   end

   // Stage B: difference, sign and magnitude
   logic signed [C-1:0] b_cur_ff [LANES];
   logic signed [C-1:0] b_tgt_ff [LANES];
   logic [LANES-1:0]    b_neg_ff;
   logic [MW-1:0]       b_mag_ff [LANES];
   logic [C-2:0]        b_step_ff;
   logic                b_v_ff;
   logic [LANES-1:0]    b_neg_in;
   logic [MW-1:0]       b_mag_in [LANES];

   always_comb begin
      logic signed [C:0] d;
      for (int l = 0; l < LANES; l++) begin
         d = $signed({a_tgt_ff[l][C-1], a_tgt_ff[l]}) - $signed({a_cur_ff[l][C-1], a_cur_ff[l]});
         b_neg_in[l] = d[C];
         b_mag_in[l] = d[C] ? MW'(-d) : MW'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         b_cur_ff  <= a_cur_ff;
         b_tgt_ff  <= a_tgt_ff;
         b_neg_ff  <= b_neg_in;
         b_mag_ff  <= b_mag_in;
         b_step_ff <= a_step_ff;
      end
   end

   // Stage C: square each magnitude
   logic signed [C-1:0] c_cur_ff [LANES];
   logic signed [C-1:0] c_tgt_ff [LANES];
   logic [LANES-1:0]    c_neg_ff;
   logic [MW-1:0]       c_mag_ff [LANES];
   logic [2*MW-1:0]     c_sq_ff  [LANES];
   logic [C-2:0]        c_step_ff;
   logic                c_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            c_sq_ff[l] <= b_mag_ff[l] * b_mag_ff[l];
         end
         c_cur_ff  <= b_cur_ff;
         c_tgt_ff  <= b_tgt_ff;
         c_neg_ff  <= b_neg_ff;
         c_mag_ff  <= b_mag_ff;
         c_step_ff <= b_step_ff;
      end
   end

   // Stage D: sum the squares, pack the sideband
   logic [SQW-1:0]   d_sum_ff;
   logic [SSIDE-1:0] d_side_ff;
   logic             d_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= c_v_ff;
      end
      if (en) begin
         d_sum_ff  <= SQW'(c_sq_ff[0]) + SQW'(c_sq_ff[1]) + SQW'(c_sq_ff[2]);
         d_side_ff <= {c_step_ff, c_mag_ff[2], c_mag_ff[1], c_mag_ff[0], c_neg_ff,
                       c_tgt_ff[2], c_tgt_ff[1], c_tgt_ff[0],
                       c_cur_ff[2], c_cur_ff[1], c_cur_ff[0]};
      end
   end

   // Square-root pipeline: length of the difference
   logic             s_v;
   logic [RW-1:0]    s_len;
   logic [SSIDE-1:0] s_side;

   vmt_sqrt_pipe #(.ROOT_W(RW), .SIDE_W(SSIDE)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_v     (d_v_ff),
      .in_rad   (d_sum_ff),
      .in_side  (d_side_ff),
      .out_v    (s_v),
      .out_root (s_len),
      .out_side (s_side)
   );

   // Stage E: decide reach, form the scaled numerators
   logic [C-2:0]     s_step;
   logic [MW-1:0]    s_mag [LANES];
   logic [6*C+LANES-1:0] s_pts;

   assign s_pts  = s_side[6*C+LANES-1:0];
   assign s_step = s_side[SSIDE-1 -: QW];
   for (genvar l = 0; l < LANES; l++) begin : g_unpack
      assign s_mag[l] = s_side[6*C+LANES+l*MW +: MW];
   end

   logic [NW-1:0]        e_num_ff [LANES];
   logic [RW-1:0]        e_len_ff;
   logic [C-2:0]         e_step_ff;
   logic [6*C+LANES-1:0] e_pts_ff;
   logic                 e_reached_ff;
   logic                 e_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= s_v;
      end
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            e_num_ff[l] <= s_mag[l] * s_step;
         end
         e_len_ff     <= s_len;
         e_step_ff    <= s_step;
         e_pts_ff     <= s_pts;
         e_reached_ff <= (s_len <= RW'(s_step)) || (s_len < RW'(snap_ff));
      end
   end

   // Divider pipeline: step * |d| / length per axis
   logic             q_v;
   logic [QW-1:0]    q_quo [LANES];
   logic [DSIDE-1:0] q_side;

   vmt_div_pipe #(.QW(QW), .DEN_W(RW), .NUM_W(NW), .SIDE_W(DSIDE)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_v     (e_v_ff),
      .in_num   (e_num_ff),
      .in_den   (e_len_ff),
      .in_side  ({e_reached_ff, e_pts_ff}),
      .out_v    (q_v),
      .out_quo  (q_quo),
      .out_side (q_side)
   );

   // Output stage: apply the move and saturate
   logic signed [C-1:0] o_new_in [LANES];

   always_comb begin
      logic signed [C-1:0] cur;
      logic signed [C-1:0] tgt;
      logic signed [C:0]   mv;
      logic signed [C:0]   sum;
      for (int l = 0; l < LANES; l++) begin
         cur = q_side[l*C +: C];
         tgt = q_side[LANES*C + l*C +: C];
         mv  = $signed({2'b00, q_quo[l]});
         if (q_side[6*C+l]) begin
            mv = -mv;
         end
         sum = $signed({cur[C-1], cur}) + mv;
         if (q_side[DSIDE-1]) begin
            o_new_in[l] = tgt;
         end else if (sum[C] != sum[C-1]) begin
            o_new_in[l] = sum[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
         end else begin
            o_new_in[l] = sum[C-1:0];
         end
      end
   end

   logic                o_v_ff;
   logic signed [C-1:0] o_new_ff [LANES];
   logic                o_reached_ff;

   assign en = !o_v_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= q_v;
      end
      if (en) begin
         o_new_ff     <= o_new_in;
         o_reached_ff <= q_side[DSIDE-1];
      end
   end

   assign rsp_ch.valid   = o_v_ff;
   assign rsp_ch.new_x   = o_new_ff[0];
   assign rsp_ch.new_y   = o_new_ff[1];
   assign rsp_ch.new_z   = o_new_ff[2];
   assign rsp_ch.reached = o_reached_ff;

   // A word that moves and is not reached has a length beyond its step
   a_move_len: assert property (@(posedge clock) disable iff (reset)
      (e_v_ff && !e_reached_ff) |-> (e_len_ff > RW'(e_step_ff)))
      else $error("move issued with length not above step");

   // A frozen pipeline keeps the output valid, the x coordinate and the reached flag
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && !rsp_ch.ready) |=> (o_v_ff && $stable(o_new_ff[0]) && $stable(o_reached_ff)))
      else $error("output word changed while stalled");

   // No word leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !o_v_ff)
      else $error("output valid right after reset");

   // Input is taken exactly when the pipeline advances
   a_ready_en: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> $past(en) && a_v_ff)
      else $error("accepted word did not enter the pipeline");

endmodule
